[src/scfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared constants, codes and types of the size-class free-list pool.
// ----------------------------------------------------------------------------
package scfp_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_NUM_CLASSES = 9;
    localparam int DEF_ADDR_WIDTH  = 32;

    localparam int MIN_CLASS_SIZE  = 16;
    localparam int SIZE_W          = 16;
    localparam int CLASS_OUT_W     = 4;
    localparam int GRANT_W         = 32;
    localparam int MIN_W           = 13;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [MIN_W-1:0] MIN_SIZE_RESET = 13'd16;

    // register index as taken from paddr[2]
    localparam logic REG_MIN_OBJECT_SIZE = 1'b0;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_POOL_HIT      = 3'd0,
        ST_GENERAL_ALLOC = 3'd1,
        ST_REFUSED       = 3'd2,
        ST_POOLED        = 3'd3,
        ST_GENERAL_FREE  = 3'd4
    } status_t;

    typedef struct packed {
        status_t                  status;
        logic [CLASS_OUT_W-1:0]   class_idx;
        logic                     pop;
    } result_t;

endpackage

[src/scfp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module scfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 576
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/scfp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_ctrl
// Size-class decode, per-class fill counts and stack memory command for
// one request.
// ----------------------------------------------------------------------------
module scfp_ctrl #(
    parameter int STACK_DEPTH = scfp_pkg::DEF_STACK_DEPTH,
    parameter int NUM_CLASSES = scfp_pkg::DEF_NUM_CLASSES,
    parameter int ADDR_WIDTH  = scfp_pkg::DEF_ADDR_WIDTH,
    localparam int RAM_DEPTH  = NUM_CLASSES * STACK_DEPTH,
    localparam int RAM_AW     = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic                               op,
    input  logic [scfp_pkg::SIZE_W-1:0]        object_size,
    input  logic [scfp_pkg::GRANT_W-1:0]       block_addr,
    input  logic                               block_is_object,
    input  logic [scfp_pkg::SIZE_W-1:0]        block_mem_size,
    input  logic [scfp_pkg::MIN_W-1:0]         min_object_size,
    output logic                               ram_en,
    output logic                               ram_we,
    output logic [RAM_AW-1:0]                  ram_addr,
    output logic [ADDR_WIDTH-1:0]              ram_wdata,
    output scfp_pkg::result_t                  result
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CMP_W = (NUM_CLASSES + 4 > scfp_pkg::SIZE_W) ? NUM_CLASSES + 4
                                                                 : scfp_pkg::SIZE_W;
    localparam logic [CMP_W-1:0] MAX_CLASS_SIZE =
        CMP_W'(scfp_pkg::MIN_CLASS_SIZE) << (NUM_CLASSES - 1);

    logic [CNT_W-1:0] counts_reg  [NUM_CLASSES];
    logic [CNT_W-1:0] counts_next [NUM_CLASSES];

    logic [CMP_W-1:0] osize_ext;
    logic [CMP_W-1:0] msize_ext;
    logic [scfp_pkg::SIZE_W-1:0] min_ext;
    logic [CLS_W-1:0] cls;
    logic [CNT_W-1:0] cnt_sel;
    logic [CNT_W-1:0] offset;
    logic             push;
    logic             pop;
    logic             rejected;

    assign osize_ext = CMP_W'(object_size);
    assign msize_ext = CMP_W'(block_mem_size);
    assign min_ext   = scfp_pkg::SIZE_W'(min_object_size);

    // thresholds are monotonic: the last one below the size sets the class
    always_comb
    begin
        cls = '0;
        for (int i = 0; i < NUM_CLASSES - 1; i++)
        begin
            if ((CMP_W'(scfp_pkg::MIN_CLASS_SIZE) << i) < osize_ext)
            begin
                cls = CLS_W'(i + 1);
            end
        end
    end

    assign cnt_sel  = counts_reg[cls];
    assign rejected = !block_is_object || (block_mem_size < min_ext) ||
                      (msize_ext > MAX_CLASS_SIZE) || (object_size < min_ext) ||
                      (osize_ext > MAX_CLASS_SIZE);

    always_comb
    begin
        result.status    = scfp_pkg::ST_GENERAL_FREE;
        result.class_idx = '0;
        pop              = 1'b0;
        push             = 1'b0;
        case (scfp_pkg::op_t'(op))
            scfp_pkg::OP_ALLOC:
            begin
                if (object_size < min_ext)
                begin
                    result.status = scfp_pkg::ST_REFUSED;
                end
                else if (osize_ext > MAX_CLASS_SIZE)
                begin
                    result.status = scfp_pkg::ST_GENERAL_ALLOC;
                end
                else
                begin
                    result.class_idx = scfp_pkg::CLASS_OUT_W'(cls);
                    if (cnt_sel == '0)
                    begin
                        result.status = scfp_pkg::ST_GENERAL_ALLOC;
                    end
                    else
                    begin
                        result.status = scfp_pkg::ST_POOL_HIT;
                        pop           = 1'b1;
                    end
                end
            end
            scfp_pkg::OP_RELEASE:
            begin
                if (!rejected)
                begin
                    result.class_idx = scfp_pkg::CLASS_OUT_W'(cls);
                    if (cnt_sel != CNT_W'(STACK_DEPTH))
                    begin
                        result.status = scfp_pkg::ST_POOLED;
                        push          = 1'b1;
                    end
                end
            end
            default:
            begin
                result.status = scfp_pkg::ST_GENERAL_FREE;
            end
        endcase
        result.pop = pop;
    end

    // pop reads the top entry, push writes one above it
    assign offset    = pop ? (cnt_sel - 1'b1) : cnt_sel;
    assign ram_addr  = RAM_AW'(cls) * RAM_AW'(STACK_DEPTH) + RAM_AW'(offset);
    assign ram_en    = accept && (pop || push);
    assign ram_we    = push;
    assign ram_wdata = ADDR_WIDTH'(block_addr);

    always_comb
    begin
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            counts_next[i] = counts_reg[i];
        end
        if (accept && push)
        begin
            counts_next[cls] = cnt_sel + 1'b1;
        end
        else if (accept && pop)
        begin
            counts_next[cls] = cnt_sel - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                counts_reg[i] <= counts_next[i];
            end
        end
    end

endmodule

[src/size_class_free_list_pool.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_free_list_pool
// Segregated free-list pool: power-of-two size classes, each a bounded
// stack of free block addresses held in one stack RAM.
// ----------------------------------------------------------------------------
//  channel   handshake              beat contents
//  in        in_valid / in_stall    op, object_size, block_addr,
//                                   block_is_object, block_mem_size
//  out       out_valid / out_stall  status, granted_addr, class_idx
//  cfg       APB psel/penable       min_object_size at byte address 0
//
//  One request per cycle while in_stall is low; decode and the stack RAM
//  read register at the accepting edge, and the output register loads
//  from them when it is empty or its result is taken, offering the result.
//  Fill counts live in flops, so a pop directly after a push to the same
//  class reads the entry the push wrote at the edge before.
//  Reset clears the fill counts and sets the minimum size to 16; no RAM clear.
//  in_stall rises only while the output register is full and stalled and
//  the RAM stage holds a result.
// ----------------------------------------------------------------------------
module size_class_free_list_pool #(
    parameter int STACK_DEPTH = scfp_pkg::DEF_STACK_DEPTH,
    parameter int NUM_CLASSES = scfp_pkg::DEF_NUM_CLASSES,
    parameter int ADDR_WIDTH  = scfp_pkg::DEF_ADDR_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scfp_pkg::PADDR_W-1:0]        paddr,
    input  logic [scfp_pkg::PDATA_W-1:0]        pwdata,
    output logic [scfp_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [scfp_pkg::SIZE_W-1:0]         object_size,
    input  logic [scfp_pkg::GRANT_W-1:0]        block_addr,
    input  logic                                block_is_object,
    input  logic [scfp_pkg::SIZE_W-1:0]         block_mem_size,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          status,
    output logic [scfp_pkg::GRANT_W-1:0]        granted_addr,
    output logic [scfp_pkg::CLASS_OUT_W-1:0]    class_idx
);

    localparam int RAM_DEPTH = NUM_CLASSES * STACK_DEPTH;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    logic [scfp_pkg::MIN_W-1:0] min_size_reg;
    logic                       cfg_write;

    logic                       accept;
    logic                       advance;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    scfp_pkg::result_t          s1_res_reg;
    scfp_pkg::result_t          res;

    logic                       ram_en;
    logic                       ram_we;
    logic [RAM_AW-1:0]          ram_addr;
    logic [ADDR_WIDTH-1:0]      ram_wdata;
    logic [ADDR_WIDTH-1:0]      ram_rdata;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    scfp_pkg::status_t                  out_status_reg;
    logic [scfp_pkg::GRANT_W-1:0]       out_addr_reg;
    logic [scfp_pkg::CLASS_OUT_W-1:0]   out_class_reg;

    // configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == scfp_pkg::REG_MIN_OBJECT_SIZE);
    assign prdata    = (paddr[2] == scfp_pkg::REG_MIN_OBJECT_SIZE) ?
                       scfp_pkg::PDATA_W'(min_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg <= scfp_pkg::MIN_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            min_size_reg <= pwdata[scfp_pkg::MIN_W-1:0];
        end
    end

    // handshake: the RAM stage drains whenever the output register is free
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    scfp_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_CLASSES (NUM_CLASSES),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .op              (op),
        .object_size     (object_size),
        .block_addr      (block_addr),
        .block_is_object (block_is_object),
        .block_mem_size  (block_mem_size),
        .min_object_size (min_size_reg),
        .ram_en          (ram_en),
        .ram_we          (ram_we),
        .ram_addr        (ram_addr),
        .ram_wdata       (ram_wdata),
        .result          (res)
    );

    scfp_ram #(
        .WIDTH (ADDR_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (advance)
        begin
            out_status_reg <= s1_res_reg.status;
            out_class_reg  <= s1_res_reg.class_idx;
            out_addr_reg   <= s1_res_reg.pop ? scfp_pkg::GRANT_W'(ram_rdata) : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign granted_addr = out_addr_reg;
    assign class_idx    = out_class_reg;

`ifndef ASSERT_OFF
    // hold input only when both stages are occupied
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // a pending result reaches an empty output register at the next edge
    a_drain_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("RAM stage did not drain into empty output register");

    // only a pool hit carries a granted address
    a_grant_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != scfp_pkg::ST_POOL_HIT))
            |-> (out_addr_reg == '0))
        else $error("granted address on a non-hit result");

    // the stack RAM is touched only by an accepted request
    a_ram_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_en |-> accept)
        else $error("stack RAM access without an accepted beat");
`endif

endmodule

[sim/scfp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_checker
// Watches the request, result and register ports of the size-class pool.
// Keeps its own copy of the class stacks and the minimum size, works out
// the reply to every accepted request beat and compares it with the result
// beats in order.
// ----------------------------------------------------------------------------
module scfp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [scfp_pkg::PADDR_W-1:0]        paddr,
    input  logic [scfp_pkg::PDATA_W-1:0]        pwdata,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                op,
    input  logic [scfp_pkg::SIZE_W-1:0]         object_size,
    input  logic [scfp_pkg::GRANT_W-1:0]        block_addr,
    input  logic                                block_is_object,
    input  logic [scfp_pkg::SIZE_W-1:0]         block_mem_size,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [2:0]                          status,
    input  logic [scfp_pkg::GRANT_W-1:0]        granted_addr,
    input  logic [scfp_pkg::CLASS_OUT_W-1:0]    class_idx,
    output int                                  errors,
    output int                                  outstanding
);

    localparam int DEPTH    = scfp_pkg::DEF_STACK_DEPTH;
    localparam int NCLS     = scfp_pkg::DEF_NUM_CLASSES;
    localparam int MAX_SIZE = scfp_pkg::MIN_CLASS_SIZE << (NCLS - 1);

    typedef struct {
        scfp_pkg::status_t                status;
        logic [scfp_pkg::GRANT_W-1:0]     addr;
        logic [scfp_pkg::CLASS_OUT_W-1:0] cls;
    } reply_t;

    reply_t                       pool_replies[$];
    logic [scfp_pkg::GRANT_W-1:0] free_addrs [NCLS][DEPTH];
    int                           fill [NCLS];
    int                           min_size;
    int                           shown;

    function automatic int size_to_class(int sz);
        int idx;
        idx = 0;
        while (idx + 1 < NCLS && (scfp_pkg::MIN_CLASS_SIZE << idx) < sz)
            idx++;
        return idx;
    endfunction

    function automatic reply_t predict_reply(logic rel, int osize,
                                             logic [scfp_pkg::GRANT_W-1:0] addr,
                                             logic obj, int msize);
        reply_t r;
        int     c;
        r.status = scfp_pkg::ST_GENERAL_ALLOC;
        r.addr   = '0;
        r.cls    = '0;
        if (rel == scfp_pkg::OP_ALLOC) begin
            if (osize < min_size)
                r.status = scfp_pkg::ST_REFUSED;
            else if (osize > MAX_SIZE)
                r.status = scfp_pkg::ST_GENERAL_ALLOC;
            else begin
                c     = size_to_class(osize);
                r.cls = c[scfp_pkg::CLASS_OUT_W-1:0];
                if (fill[c] == 0)
                    r.status = scfp_pkg::ST_GENERAL_ALLOC;
                else begin
                    fill[c]--;
                    r.addr   = free_addrs[c][fill[c]];
                    r.status = scfp_pkg::ST_POOL_HIT;
                end
            end
        end else begin
            if (!obj || msize < min_size || msize > MAX_SIZE ||
                osize < min_size || osize > MAX_SIZE)
                r.status = scfp_pkg::ST_GENERAL_FREE;
            else begin
                c     = size_to_class(osize);
                r.cls = c[scfp_pkg::CLASS_OUT_W-1:0];
                // full stack: hand the block to general free, store nothing
                if (fill[c] >= DEPTH)
                    r.status = scfp_pkg::ST_GENERAL_FREE;
                else begin
                    free_addrs[c][fill[c]] = addr;
                    fill[c]++;
                    r.status = scfp_pkg::ST_POOLED;
                end
            end
        end
        return r;
    endfunction

    task automatic flag(string msg);
        errors++;
        if (shown < 10)
        begin
            $display("%0t checker: %s", $realtime, msg);
            shown++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            pool_replies.delete();
            fill        = '{default: 0};
            min_size    = scfp_pkg::MIN_SIZE_RESET;
            errors      = 0;
            shown       = 0;
            outstanding = 0;
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[scfp_pkg::PADDR_W-1:2] == scfp_pkg::REG_MIN_OBJECT_SIZE)
                min_size = pwdata[scfp_pkg::MIN_W-1:0];
            // retire the result beat before the request beat of the same edge
            if (out_valid && !out_stall)
            begin
                if (pool_replies.size() == 0)
                    flag($sformatf("unexpected result: status %0d addr %h class %0d",
                                   status, granted_addr, class_idx));
                else begin
                    want = pool_replies.pop_front();
                    if (status !== want.status || granted_addr !== want.addr ||
                        class_idx !== want.cls)
                        flag($sformatf({"mismatch: expected status %0d addr %h class %0d,",
                                        " got status %0d addr %h class %0d"},
                                       want.status, want.addr, want.cls,
                                       status, granted_addr, class_idx));
                end
            end
            if (in_valid && !in_stall)
                pool_replies.push_back(predict_reply(op, int'(object_size), block_addr,
                                                     block_is_object, int'(block_mem_size)));
            outstanding = pool_replies.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the size-class free-list pool: directed corner requests, then
// random allocate/release traffic that fills and drains chosen classes under
// several minimum sizes and stall patterns. The checker judges every beat.
// ----------------------------------------------------------------------------
module tb;

    localparam int PERIOD      = 20;
    localparam int NCLS        = scfp_pkg::DEF_NUM_CLASSES;
    localparam int MAX_SIZE    = scfp_pkg::MIN_CLASS_SIZE << (NCLS - 1);
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 80;
    localparam int SEG_LEN     = 60;

    localparam logic [scfp_pkg::PADDR_W-1:0] ADDR_MIN_SIZE =
        {scfp_pkg::REG_MIN_OBJECT_SIZE, 2'b00};
    localparam logic [scfp_pkg::PADDR_W-1:0] ADDR_UNUSED   =
        {~scfp_pkg::REG_MIN_OBJECT_SIZE, 2'b00};

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             psel, penable, pwrite;
    logic [scfp_pkg::PADDR_W-1:0]     paddr;
    logic [scfp_pkg::PDATA_W-1:0]     pwdata;
    logic [scfp_pkg::PDATA_W-1:0]     prdata;
    logic                             pready;
    logic                             in_valid, in_stall;
    logic                             op;
    logic [scfp_pkg::SIZE_W-1:0]      object_size;
    logic [scfp_pkg::GRANT_W-1:0]     block_addr;
    logic                             block_is_object;
    logic [scfp_pkg::SIZE_W-1:0]      block_mem_size;
    logic                             out_valid, out_stall;
    logic [2:0]                       status;
    logic [scfp_pkg::GRANT_W-1:0]     granted_addr;
    logic [scfp_pkg::CLASS_OUT_W-1:0] class_idx;

    int   fail_count;
    int   pending;
    int   quiet = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    int   min_size = scfp_pkg::MIN_SIZE_RESET;
    int   focus_cls = 0;
    int   seg_pos = 0;
    int   seg_idx = 0;

    always #(PERIOD / 2) clk = ~clk;

    size_class_free_list_pool dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .object_size     (object_size),
        .block_addr      (block_addr),
        .block_is_object (block_is_object),
        .block_mem_size  (block_mem_size),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .granted_addr    (granted_addr),
        .class_idx       (class_idx)
    );

    scfp_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .object_size     (object_size),
        .block_addr      (block_addr),
        .block_is_object (block_is_object),
        .block_mem_size  (block_mem_size),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .granted_addr    (granted_addr),
        .class_idx       (class_idx),
        .errors          (fail_count),
        .outstanding     (pending)
    );

    // receiver: random stalls, or one long hold-off when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            out_stall = ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [scfp_pkg::PADDR_W-1:0] addr,
                             logic [scfp_pkg::PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // wait for every outstanding reply, then let the pipeline empty
    task automatic settle();
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_min_size(int v);
        settle();
        reg_write(ADDR_MIN_SIZE, v);
        min_size = v;
    endtask

    task automatic send_beat(scfp_pkg::op_t o, logic [scfp_pkg::SIZE_W-1:0] os,
                             logic [scfp_pkg::GRANT_W-1:0] a, logic obj,
                             logic [scfp_pkg::SIZE_W-1:0] ms);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid        = 1'b1;
        op              = o;
        object_size     = os;
        block_addr      = a;
        block_is_object = obj;
        block_mem_size  = ms;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [scfp_pkg::SIZE_W-1:0] pick_size(int c);
        int r, hi, lo;
        r  = $urandom_range(99);
        hi = scfp_pkg::MIN_CLASS_SIZE << c;
        lo = (c == 0) ? 0 : hi / 2 + 1;
        if (lo < min_size)
            lo = min_size;
        if (lo > hi)
            lo = hi;
        if (r < 10)
            return scfp_pkg::SIZE_W'($urandom_range(16'hFFFF, 0));
        if (r < 18)
        begin
            case ($urandom_range(4))
                0:       return scfp_pkg::SIZE_W'(min_size - 1);
                1:       return scfp_pkg::SIZE_W'(min_size);
                2:       return scfp_pkg::SIZE_W'(MAX_SIZE);
                3:       return scfp_pkg::SIZE_W'(MAX_SIZE + 1);
                default: return '0;
            endcase
        end
        return scfp_pkg::SIZE_W'($urandom_range(hi, lo));
    endfunction

    // segments of SEG_LEN beats: two release-heavy, two allocate-heavy per focus class
    task automatic send_random(int n);
        int                          lo_cls, c;
        logic                        rel, obj, filling;
        logic [scfp_pkg::SIZE_W-1:0] ms;
        lo_cls = 0;
        while (lo_cls < NCLS - 1 && (scfp_pkg::MIN_CLASS_SIZE << lo_cls) < min_size)
            lo_cls++;
        for (int i = 0; i < n; i++)
        begin
            if (seg_pos == 0 && (seg_idx % 4 == 0 || focus_cls < lo_cls))
                focus_cls = $urandom_range(NCLS - 1, lo_cls);
            filling = (seg_idx % 4) < 2;
            c       = ($urandom_range(99) < 80) ? focus_cls : $urandom_range(NCLS - 1, 0);
            rel     = ($urandom_range(99) < (filling ? 75 : 25));
            obj     = ($urandom_range(99) < 92);
            ms      = ($urandom_range(99) < 85) ?
                      scfp_pkg::SIZE_W'($urandom_range(MAX_SIZE, min_size)) :
                      scfp_pkg::SIZE_W'($urandom_range(16'hFFFF, 0));
            send_beat(rel ? scfp_pkg::OP_RELEASE : scfp_pkg::OP_ALLOC, pick_size(c),
                      $urandom, obj, ms);
            seg_pos++;
            if (seg_pos == SEG_LEN)
            begin
                seg_pos = 0;
                seg_idx++;
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        op              = scfp_pkg::OP_ALLOC;
        object_size     = '0;
        block_addr      = '0;
        block_is_object = 1'b0;
        block_mem_size  = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_min_size(16);
        send_beat(scfp_pkg::OP_ALLOC,   16'd16,   32'h0,        1'b0, 16'd0);   // empty class
        send_beat(scfp_pkg::OP_ALLOC,   16'd15,   32'h0,        1'b0, 16'd0);   // below minimum
        send_beat(scfp_pkg::OP_ALLOC,   16'd0,    32'h0,        1'b0, 16'd0);
        send_beat(scfp_pkg::OP_ALLOC,   16'd4097, 32'h0,        1'b0, 16'd0);   // above largest
        send_beat(scfp_pkg::OP_ALLOC,   16'hFFFF, 32'hFFFFFFFF, 1'b1, 16'hFFFF);
        send_beat(scfp_pkg::OP_RELEASE, 16'd64,   32'h1234,     1'b0, 16'd64);  // not an object
        send_beat(scfp_pkg::OP_RELEASE, 16'd64,   32'h1234,     1'b1, 16'd15);
        send_beat(scfp_pkg::OP_RELEASE, 16'd64,   32'h1234,     1'b1, 16'd4097);
        send_beat(scfp_pkg::OP_RELEASE, 16'd4097, 32'h1234,     1'b1, 16'd64);
        send_beat(scfp_pkg::OP_RELEASE, 16'd15,   32'h1234,     1'b1, 16'd64);
        send_beat(scfp_pkg::OP_RELEASE, 16'd4096, 32'hFFFFFFFF, 1'b1, 16'd4096);
        send_beat(scfp_pkg::OP_RELEASE, 16'd17,   32'h0,        1'b1, 16'd17);
        send_beat(scfp_pkg::OP_RELEASE, 16'd16,   32'hA5A5A5A5, 1'b1, 16'd16);
        send_beat(scfp_pkg::OP_RELEASE, 16'd16,   32'h1,        1'b1, 16'hFFFF);
        send_beat(scfp_pkg::OP_ALLOC,   16'd16,   32'h0,        1'b0, 16'd0);
        send_beat(scfp_pkg::OP_RELEASE, 16'd32,   32'h5A5A5A5A, 1'b1, 16'd32);
        send_beat(scfp_pkg::OP_ALLOC,   16'd32,   32'h0,        1'b0, 16'd0);   // pop after push
        send_beat(scfp_pkg::OP_ALLOC,   16'd17,   32'h0,        1'b0, 16'd0);
        send_beat(scfp_pkg::OP_ALLOC,   16'd4096, 32'h0,        1'b0, 16'd0);
        send_beat(scfp_pkg::OP_ALLOC,   16'd2048, 32'h0,        1'b0, 16'd0);
        send_beat(scfp_pkg::OP_ALLOC,   16'd1024, 32'h0,        1'b0, 16'd0);
        settle();
        reg_write(ADDR_UNUSED, 32'd1);                                  // must be dropped
        send_beat(scfp_pkg::OP_ALLOC,   16'd15,   32'h0,        1'b0, 16'd0);
        set_min_size(1);
        send_beat(scfp_pkg::OP_ALLOC,   16'd0,    32'h0,        1'b0, 16'd0);
        send_beat(scfp_pkg::OP_RELEASE, 16'd1,    32'h00C0FFEE, 1'b1, 16'd1);
        send_beat(scfp_pkg::OP_ALLOC,   16'd1,    32'h0,        1'b0, 16'd0);

        tx_idle_pct  = 36;
        rx_stall_pct = 87;
        send_random(500);

        set_min_size(4096);
        tx_idle_pct  = 87;
        rx_stall_pct = 36;
        send_random(200);
        set_min_size($urandom_range(1000, 17));
        send_random(350);

        set_min_size(16);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_random(150);
        // long receiver hold-off while beats keep coming: fill the pipeline
        hold_req = ~hold_req;
        send_random(150);
        settle();
        send_random(250);

        settle();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
